[rtl/core/wheel_speed_mixer_keep_rotation_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the wheel speed mixer
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WHEEL_SPEED_MIXER_KEEP_ROTATION_MACROS_SVH
`define WHEEL_SPEED_MIXER_KEEP_ROTATION_MACROS_SVH
`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle
`define WSMKR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsmkr: assertion failed");
// consequent must hold in the next cycle
`define WSMKR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsmkr: assertion failed");
`else
`define WSMKR_ASSERT_NOW(lbl, ante, cons)
`define WSMKR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/wsmkr_pkg.sv]
// ---------------------------------------------------------------------------
// wsmkr_pkg
// Types and constants shared by the wheel speed mixer modules.
// ---------------------------------------------------------------------------
package wsmkr_pkg;

  localparam int WHEELS  = 4;
  localparam int SPD_W   = 32;
  localparam int GAIN_W  = 17;
  localparam int FRAC_W  = 16;
  localparam int ONE_Q16 = 65536;
  localparam int OVER_QW = 31;   // quotient bits, rotation rescale
  localparam int MIX_QW  = 17;   // quotient bits, gain candidate
  localparam int CNT_W   = $clog2(OVER_QW);
  localparam int QDEPTH  = 2;
  localparam int PTR_W   = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [SPD_W-1:0] trans_a;
    logic signed [SPD_W-1:0] trans_b;
    logic signed [SPD_W-1:0] trans_c;
    logic signed [SPD_W-1:0] trans_d;
    logic signed [SPD_W-1:0] rot_a;
    logic signed [SPD_W-1:0] rot_b;
    logic signed [SPD_W-1:0] rot_c;
    logic signed [SPD_W-1:0] rot_d;
  } in_item_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] cmd_a;
    logic signed [SPD_W-1:0] cmd_b;
    logic signed [SPD_W-1:0] cmd_c;
    logic signed [SPD_W-1:0] cmd_d;
    logic [GAIN_W-1:0]       translation_gain;
    logic                    ok;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_OVER,
    KIND_MIX
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic [SPD_W-1:0]             peak;
    logic [WHEELS-1:0][SPD_W-1:0] tr;
    logic [WHEELS-1:0][SPD_W-1:0] ro;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

[rtl/core/wsmkr_front.sv]
// ---------------------------------------------------------------------------
// wsmkr_front
// Takes input items, finds the rotation peak and classifies each item.
// ---------------------------------------------------------------------------
module wsmkr_front (
  input  wsmkr_pkg::in_item_t         in_data,
  input  logic                        in_valid,
  input  logic signed [31:0]          speed_limit,
  input  wsmkr_pkg::q_stat_t          q_stat,
  output logic                        push,
  output wsmkr_pkg::job_t             job
);
  import wsmkr_pkg::*;

  logic [WHEELS-1:0][SPD_W-1:0] tr_v;
  logic [WHEELS-1:0][SPD_W-1:0] ro_v;
  logic [WHEELS-1:0][SPD_W-1:0] mag;
  logic                         lim_pos;
  logic                         over;
  logic [SPD_W-1:0]             peak;

  always_comb begin
    tr_v[0] = in_data.trans_a;
    tr_v[1] = in_data.trans_b;
    tr_v[2] = in_data.trans_c;
    tr_v[3] = in_data.trans_d;
    ro_v[0] = in_data.rot_a;
    ro_v[1] = in_data.rot_b;
    ro_v[2] = in_data.rot_c;
    ro_v[3] = in_data.rot_d;
    lim_pos = !speed_limit[SPD_W-1] && (speed_limit != '0);
    over    = 1'b0;
    peak    = '0;
    for (int i = 0; i < WHEELS; i++) begin
      // magnitude of the most negative value still fits unsigned
      mag[i] = ro_v[i][SPD_W-1] ? (~ro_v[i] + SPD_W'(1)) : ro_v[i];
      if (mag[i] > $unsigned(speed_limit)) over = 1'b1;
      if (mag[i] > peak) peak = mag[i];
    end
    job.kind = !lim_pos ? KIND_ZERO : (over ? KIND_OVER : KIND_MIX);
    job.peak = peak;
    job.tr   = tr_v;
    job.ro   = ro_v;
  end

  assign push = in_valid && !q_stat.full;

endmodule

[rtl/core/wsmkr_queue.sv]
// ---------------------------------------------------------------------------
// wsmkr_queue
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
module wsmkr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wsmkr_pkg::job_t    job_in,
  input  logic               pop,
  output wsmkr_pkg::job_t    job_out,
  output wsmkr_pkg::q_stat_t q_stat
);
  import wsmkr_pkg::*;

  job_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == (PTR_W+1)'(QDEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign job_out      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/core/wsmkr_back.sv]
// ---------------------------------------------------------------------------
// wsmkr_back
// Per-wheel radix-2 dividers, gain selection, mixing and output register.
// ---------------------------------------------------------------------------
`include "wheel_speed_mixer_keep_rotation_macros.svh"

module wsmkr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsmkr_pkg::job_t      job,
  input  wsmkr_pkg::q_stat_t   q_stat,
  output logic                 pop,
  input  logic signed [31:0]   speed_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wsmkr_pkg::out_item_t out_data
);
  import wsmkr_pkg::*;

  localparam int NUM_W  = 64;
  localparam int PROD_W = GAIN_W + 1 + SPD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t                       state_r;
  kind_t                        kind_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [NUM_W-1:0]             rem_r  [WHEELS];
  logic [NUM_W-1:0]             ds_r   [WHEELS];
  logic [SPD_W-1:0]             quo_r  [WHEELS];
  logic [WHEELS-1:0]            neg_r;
  logic [WHEELS-1:0]            ovf_r;
  logic [WHEELS-1:0]            skip_r;
  logic [WHEELS-1:0][SPD_W-1:0] tr_r;
  logic [WHEELS-1:0][SPD_W-1:0] ro_r;
  logic [GAIN_W-1:0]            gain_r;
  logic signed [PROD_W-1:0]     prod_r [WHEELS];
  out_item_t                    res_r;
  logic                         out_valid_r;
  out_item_t                    out_data_r;

  // load values
  logic signed [NUM_W-1:0]      ld_prod [WHEELS];
  logic signed [SPD_W+1:0]      ld_diff [WHEELS];
  logic [SPD_W+1:0]             ld_dmag [WHEELS];
  logic [SPD_W-1:0]             ld_tmag [WHEELS];
  logic [NUM_W-1:0]             ld_rem  [WHEELS];
  logic [NUM_W-1:0]             ld_ds   [WHEELS];
  logic [WHEELS-1:0]            ld_neg;
  logic [WHEELS-1:0]            ld_ovf;
  logic [WHEELS-1:0]            ld_skip;
  logic signed [SPD_W+1:0]      lim34;
  // divider step
  logic [WHEELS-1:0]            ge;
  logic [NUM_W-1:0]             rem_nxt [WHEELS];
  logic [SPD_W-1:0]             quo_nxt [WHEELS];
  // gain
  logic signed [GAIN_W:0]       cand    [WHEELS];
  logic signed [GAIN_W:0]       one_s;
  logic signed [GAIN_W:0]       gmin;
  logic [GAIN_W-1:0]            gain_nxt;
  // mixing
  logic signed [PROD_W-1:0]     prod_nxt [WHEELS];
  logic signed [PROD_W-1:0]     rnd      [WHEELS];
  logic signed [SPD_W+2:0]      mix_v    [WHEELS];
  logic signed [SPD_W+2:0]      lim35;
  logic [SPD_W-1:0]             fin_cmd  [WHEELS];
  out_item_t                    fin_res;

  assign pop       = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    lim34 = {{2{speed_limit[SPD_W-1]}}, speed_limit};
    lim35 = {{3{speed_limit[SPD_W-1]}}, speed_limit};
    one_s = $signed((GAIN_W+1)'(ONE_Q16));
    gmin  = one_s;
    for (int i = 0; i < WHEELS; i++) begin
      // rotation rescale: |rot * limit| / peak
      ld_prod[i] = $signed(job.ro[i]) * speed_limit;
      // gain candidate: |bound - rot| << 16 / |trans|
      ld_diff[i] = (job.tr[i][SPD_W-1] ? -lim34 : lim34)
                   - $signed({{2{job.ro[i][SPD_W-1]}}, job.ro[i]});
      ld_dmag[i] = ld_diff[i][SPD_W+1] ? (~ld_diff[i] + (SPD_W+2)'(1)) : ld_diff[i];
      ld_tmag[i] = job.tr[i][SPD_W-1] ? (~job.tr[i] + SPD_W'(1)) : job.tr[i];
      ld_skip[i] = (job.tr[i] == '0);
      if (job.kind == KIND_OVER) begin
        ld_rem[i] = ld_prod[i][NUM_W-1] ? (~ld_prod[i] + NUM_W'(1)) : ld_prod[i];
        ld_ds[i]  = {{(NUM_W-SPD_W){1'b0}}, job.peak} << (OVER_QW - 1);
        ld_neg[i] = job.ro[i][SPD_W-1];
        ld_ovf[i] = 1'b0;
      end else begin
        ld_rem[i] = {{(NUM_W-SPD_W-2-FRAC_W){1'b0}}, ld_dmag[i], {FRAC_W{1'b0}}};
        ld_ds[i]  = {{(NUM_W-SPD_W){1'b0}}, ld_tmag[i]} << (MIX_QW - 1);
        ld_neg[i] = ld_diff[i][SPD_W+1] ^ job.tr[i][SPD_W-1];
        // quotient would not fit in the candidate width: saturates anyway
        ld_ovf[i] = ld_rem[i] >= ({{(NUM_W-SPD_W){1'b0}}, ld_tmag[i]} << MIX_QW);
      end

      ge[i]      = rem_r[i] >= ds_r[i];
      rem_nxt[i] = ge[i] ? (rem_r[i] - ds_r[i]) : rem_r[i];
      quo_nxt[i] = {quo_r[i][SPD_W-2:0], ge[i]};

      // only the clamped range matters for the minimum
      if (skip_r[i])                 cand[i] = one_s;
      else if (ovf_r[i])             cand[i] = neg_r[i] ? -(GAIN_W+1)'(1) : one_s;
      else if (quo_r[i] == '0)       cand[i] = '0;
      else if (neg_r[i])             cand[i] = -(GAIN_W+1)'(1);
      else if (quo_r[i] > SPD_W'(ONE_Q16)) cand[i] = one_s;
      else                           cand[i] = $signed(quo_r[i][GAIN_W:0]);
      if (cand[i] < gmin) gmin = cand[i];

      prod_nxt[i] = $signed({1'b0, gain_r}) * $signed(tr_r[i]);

      // truncating divide by 2^16, then clamp to +-limit
      rnd[i]   = prod_r[i] + (prod_r[i][PROD_W-1] ? PROD_W'(ONE_Q16 - 1) : PROD_W'(0));
      mix_v[i] = $signed({{3{ro_r[i][SPD_W-1]}}, ro_r[i]})
                 + $signed({{(SPD_W+3-(PROD_W-FRAC_W)){rnd[i][PROD_W-1]}},
                            rnd[i][PROD_W-1:FRAC_W]});
      if (kind_r == KIND_OVER)  fin_cmd[i] = neg_r[i] ? (~quo_r[i] + SPD_W'(1)) : quo_r[i];
      else if (mix_v[i] > lim35)  fin_cmd[i] = speed_limit;
      else if (mix_v[i] < -lim35) fin_cmd[i] = -speed_limit;
      else                        fin_cmd[i] = mix_v[i][SPD_W-1:0];
    end
    gain_nxt = gmin[GAIN_W] ? '0 : gmin[GAIN_W-1:0];

    fin_res.cmd_a            = fin_cmd[0];
    fin_res.cmd_b            = fin_cmd[1];
    fin_res.cmd_c            = fin_cmd[2];
    fin_res.cmd_d            = fin_cmd[3];
    fin_res.translation_gain = (kind_r == KIND_OVER) ? '0 : gain_r;
    fin_res.ok               = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            kind_r <= job.kind;
            tr_r   <= job.tr;
            ro_r   <= job.ro;
            neg_r  <= ld_neg;
            ovf_r  <= ld_ovf;
            skip_r <= ld_skip;
            for (int i = 0; i < WHEELS; i++) begin
              rem_r[i] <= ld_rem[i];
              ds_r[i]  <= ld_ds[i];
              quo_r[i] <= '0;
            end
            cnt_r <= (job.kind == KIND_OVER) ? CNT_W'(OVER_QW - 1) : CNT_W'(MIX_QW - 1);
            if (job.kind == KIND_ZERO) begin
              res_r   <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          for (int i = 0; i < WHEELS; i++) begin
            rem_r[i] <= rem_nxt[i];
            ds_r[i]  <= ds_r[i] >> 1;
            quo_r[i] <= quo_nxt[i];
          end
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) state_r <= (kind_r == KIND_OVER) ? ST_FIN : ST_GAIN;
        end
        ST_GAIN: begin
          gain_r  <= gain_nxt;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          for (int i = 0; i < WHEELS; i++) prod_r[i] <= prod_nxt[i];
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          res_r   <= fin_res;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r <= res_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `WSMKR_ASSERT_NEXT(a_gain_to_mul, state_r == ST_GAIN, state_r == ST_MUL)
  `WSMKR_ASSERT_NOW(a_gain_range, state_r == ST_MUL, gain_r <= GAIN_W'(ONE_Q16))
  `WSMKR_ASSERT_NEXT(a_div_holds, (state_r == ST_DIV) && (cnt_r != '0), state_r == ST_DIV)
  `WSMKR_ASSERT_NEXT(a_done_emits, (state_r == ST_DONE) && !out_valid_r, out_valid_r && (state_r == ST_IDLE))

endmodule

[rtl/core/wheel_speed_mixer_keep_rotation.sv]
// ---------------------------------------------------------------------------
// wheel_speed_mixer_keep_rotation
// Mixes wheel translation and rotation speeds under a speed limit,
// keeping the rotation share intact.
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  in_       in_valid / in_stall   in_data   (wsmkr_pkg::in_item_t)
//  out_      out_valid / out_stall out_data  (wsmkr_pkg::out_item_t)
//  cfg_      cfg_valid / cfg_ready cfg_data  (speed limit, Q16.16)
//
//  The back takes one item at a time through the per-wheel radix-2 dividers:
//  17 steps when translation is mixed, 31 when rotation alone is rescaled,
//  none when the limit is not positive; out_stall can hold a finished item.
//  A two-entry queue lets the front take items while the back divides.
//  Reset clears the queue, the back state and the limit (to zero).
//  in_stall is high only while the queue is full.
// ---------------------------------------------------------------------------
module wheel_speed_mixer_keep_rotation (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wsmkr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wsmkr_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);
  import wsmkr_pkg::*;

  logic signed [SPD_W-1:0] speed_limit_r;
  logic                    push;
  logic                    pop;
  job_t                    job_in;
  job_t                    job_out;
  q_stat_t                 q_stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      speed_limit_r <= $signed(cfg_data);
    end
  end

  wsmkr_front u_front (
    .in_data     (in_data),
    .in_valid    (in_valid),
    .speed_limit (speed_limit_r),
    .q_stat      (q_stat),
    .push        (push),
    .job         (job_in)
  );

  wsmkr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .q_stat  (q_stat)
  );

  wsmkr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job         (job_out),
    .q_stat      (q_stat),
    .pop         (pop),
    .speed_limit (speed_limit_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

[test/tb_wheel_speed_mixer_keep_rotation.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for wheel_speed_mixer_keep_rotation
// Drives wheel speed items under several speed limits. Each result is
// checked against a behavioural mixer model. Both sides idle at random outside
// one random-limit phase, and one long output hold-off fills the internal queue.
// ---------------------------------------------------------------------------
module tb_wheel_speed_mixer_keep_rotation;
  import wsmkr_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [31:0] cfg_data = '0;

  out_item_t expected_cmds[$];
  logic signed [31:0] limit_now;
  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  limits_set = 0;
  int  cycles = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  int  hold_off = 0;

  wheel_speed_mixer_keep_rotation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2ns clk = ~clk;

  function automatic out_item_t mix_wheels(in_item_t it, logic signed [31:0] lim_in);
    longint tr[4];
    longint ro[4];
    longint lim, peak, gain, cand, mag, v;
    bit over;
    out_item_t r;
    lim = lim_in;
    peak = 0;
    gain = ONE_Q16;
    over = 0;
    r = '0;
    tr[0] = it.trans_a; tr[1] = it.trans_b; tr[2] = it.trans_c; tr[3] = it.trans_d;
    ro[0] = it.rot_a;   ro[1] = it.rot_b;   ro[2] = it.rot_c;   ro[3] = it.rot_d;
    if (lim <= 0) return r;
    for (int i = 0; i < 4; i++) begin
      mag = ro[i] < 0 ? -ro[i] : ro[i];
      if (mag > lim) over = 1;
      if (mag > peak) peak = mag;
    end
    if (over) begin
      for (int i = 0; i < 4; i++) tr[i] = (ro[i] * lim) / peak;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (tr[i] == 0) continue;
        cand = (((tr[i] > 0 ? lim : -lim) - ro[i]) * ONE_Q16) / tr[i];
        if (cand < gain) gain = cand;
      end
      if (gain < 0) gain = 0;
      else if (gain > ONE_Q16) gain = ONE_Q16;
      for (int i = 0; i < 4; i++) begin
        v = ro[i] + (gain * tr[i]) / ONE_Q16;
        if (v > lim) v = lim;
        else if (v < -lim) v = -lim;
        tr[i] = v;
      end
      r.translation_gain = gain[16:0];
    end
    r.cmd_a = tr[0][31:0]; r.cmd_b = tr[1][31:0];
    r.cmd_c = tr[2][31:0]; r.cmd_d = tr[3][31:0];
    r.ok = 1'b1;
    return r;
  endfunction

  // wide spread of magnitudes, extremes included now and then
  function automatic logic [31:0] rand_speed(logic signed [31:0] lim);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom();
      1: v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      2: v = 32'($signed($urandom_range(0, 8)) - 4);
      3: v = lim;
      4: v = -lim;
      default: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t rand_item(logic signed [31:0] lim, bit rot_small);
    in_item_t it;
    logic [31:0] r;
    it.trans_a = rand_speed(lim); it.trans_b = rand_speed(lim);
    it.trans_c = rand_speed(lim); it.trans_d = rand_speed(lim);
    for (int i = 0; i < 4; i++) begin
      r = rand_speed(lim);
      if (rot_small && lim > 0) r = 32'($signed(r) % (lim + 1));
      case (i)
        0: it.rot_a = r; 1: it.rot_b = r; 2: it.rot_c = r; default: it.rot_d = r;
      endcase
    end
    return it;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: stall at random, or for a long stretch on request
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= out_idle_on && ($urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_data);
      end else begin
        want = expected_cmds.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // valid stays high after an item unless random idling drops it; callers drop it when done
  task automatic send_item(in_item_t it);
    while (in_idle_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_cmds.push_back(mix_wheels(it, limit_now));
    items_sent++;
  endtask

  task automatic set_limit(logic signed [31:0] lim);
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_now = lim;
    limits_set++;
  endtask

  task automatic test_directed();
    in_item_t it;
    logic signed [31:0] lims[3] = '{32'sd0, 32'sh0001_0000, 32'sh7fff_ffff};
    foreach (lims[k]) begin
      set_limit(lims[k]);
      it = '0;
      send_item(it);
      it = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1,
             32'h0, 32'hffff_ffff, 32'h8000, 32'hffff_8000};
      send_item(it);
      // rotation over the limit
      it = '{32'h1000, 32'h0, 32'h0, 32'h0,
             32'h8000_0000, 32'h7fff_ffff, 32'h2_0000, 32'hfffe_0000};
      send_item(it);
      // gain pulled down to zero
      it = '{32'h1_0000, 32'hffff_0000, 32'h0, 32'h0,
             32'h1_0000, 32'hffff_0000, 32'h0, 32'h0};
      send_item(it);
      it = '{32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000,
             32'h0, 32'h0, 32'h0, 32'h0};
      send_item(it);
    end
    set_limit(32'sh8000_0000);
    send_item('{8{32'h1234_5678}});
    set_limit(-32'sd1);
    send_item('{8{32'hffff_ffff}});
  endtask

  task automatic test_random();
    logic signed [31:0] lims[6] = '{32'sh0003_0000, 32'sd1, 32'sh0100_0000,
                                    32'sh7fff_ffff, 32'sh0000_8000, -32'sd7};
    foreach (lims[k]) begin
      set_limit(lims[k]);
      out_idle_on = (k != 2);
      in_idle_on  = (k != 2);
      for (int n = 0; n < 320; n++)
        send_item(rand_item(lims[k], $urandom_range(0, 9) < 7));
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int n = 0; n < 20; n++) send_item(rand_item(limit_now, 1'b1));
  endtask

  initial begin
    limit_now = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    set_limit(32'sh0004_0000);
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items over %0d speed limits, %0d results checked.",
             items_sent, limits_set, results_seen);
    $display("Covered zero and negative limits, rotation rescale, gain clamping, stalls.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
